// ----- sv/video_picture_header_parser_core_macros.svh -----
// Assertion macros shared by the picture header parser modules.
`ifndef VIDEO_PICTURE_HEADER_PARSER_CORE_MACROS_SVH
`define VIDEO_PICTURE_HEADER_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define VPHP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("vphp: invariant violated");
`define VPHP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vphp: implication violated");
`define VPHP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vphp: next-cycle check violated");
`else
`define VPHP_ASSERT(label, expr)
`define VPHP_ASSERT_IMP(label, ante, cons)
`define VPHP_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- sv/vphp_pkg.sv -----
// Types, phase codes and size tables of the picture header parser.
package vphp_pkg;

  localparam int unsigned AccW = 22;
  localparam logic [AccW-1:0] START_CODE = 22'h000020;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START    = 5'd1,
    PH_TREF     = 5'd2,
    PH_MARKER   = 5'd3,
    PH_ID       = 5'd4,
    PH_FLAGS    = 5'd5,
    PH_FORMAT   = 5'd6,
    PH_B_PTYPE  = 5'd7,
    PH_B_UMV    = 5'd8,
    PH_B_SAC    = 5'd9,
    PH_B_AP     = 5'd10,
    PH_B_PB     = 5'd11,
    PH_B_QS     = 5'd12,
    PH_B_CPM    = 5'd13,
    PH_X_UFEP   = 5'd14,
    PH_X_SRC    = 5'd15,
    PH_X_OPT    = 5'd16,
    PH_X_MPP    = 5'd17,
    PH_X_PTYPE  = 5'd18,
    PH_X_MODES  = 5'd19,
    PH_X_PAR    = 5'd20,
    PH_X_WIDTH  = 5'd21,
    PH_X_MARK   = 5'd22,
    PH_X_HEIGHT = 5'd23,
    PH_X_QS     = 5'd24,
    PH_PEI      = 5'd25,
    PH_PSUPP    = 5'd26,
    PH_DONE     = 5'd27
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_MARKER = 3'd2,
    ST_BAD_ID     = 3'd3,
    ST_BAD_EXT    = 3'd4,
    ST_BAD_SRC    = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic        ext;
    logic [11:0] width;
    logic [10:0] height;
    logic [3:0]  ptype;
    logic        umv;
    logic        sac;
    logic        ap;
    logic        pb;
    logic [4:0]  qs;
  } hdr_fields_t;

  typedef struct packed {
    phase_t          phase;
    logic [4:0]      left;
    logic [AccW-1:0] acc;
    hdr_fields_t     saved;
  } parse_state_t;

  typedef struct packed {
    status_t     status;
    hdr_fields_t fields;
  } hdr_result_t;

  function automatic logic [4:0] phase_len(input phase_t ph);
    logic [4:0] n;
    case (ph)
      PH_START:    n = 5'd22;
      PH_TREF:     n = 5'd8;
      PH_FLAGS:    n = 5'd3;
      PH_FORMAT:   n = 5'd3;
      PH_B_QS:     n = 5'd5;
      PH_X_UFEP:   n = 5'd3;
      PH_X_SRC:    n = 5'd3;
      PH_X_OPT:    n = 5'd12;
      PH_X_MPP:    n = 5'd3;
      PH_X_PTYPE:  n = 5'd3;
      PH_X_MODES:  n = 5'd7;
      PH_X_PAR:    n = 5'd4;
      PH_X_WIDTH:  n = 5'd9;
      PH_X_HEIGHT: n = 5'd9;
      PH_X_QS:     n = 5'd5;
      PH_PSUPP:    n = 5'd8;
      PH_IDLE:     n = 5'd0;
      PH_DONE:     n = 5'd0;
      default:     n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [11:0] fmt_width(input logic [2:0] f);
    logic [11:0] w;
    case (f)
      3'd1:    w = 12'd128;
      3'd2:    w = 12'd176;
      3'd3:    w = 12'd352;
      3'd4:    w = 12'd704;
      3'd5:    w = 12'd1408;
      3'd6:    w = 12'd320;
      default: w = 12'd0;
    endcase
    return w;
  endfunction

  function automatic logic [10:0] fmt_height(input logic [2:0] f);
    logic [10:0] h;
    case (f)
      3'd1:    h = 11'd96;
      3'd2:    h = 11'd144;
      3'd3:    h = 11'd288;
      3'd4:    h = 11'd576;
      3'd5:    h = 11'd1152;
      3'd6:    h = 11'd240;
      default: h = 11'd0;
    endcase
    return h;
  endfunction

endpackage

// ----- sv/vphp_bit_step.sv -----
// One bit step of the header parser: shift a bit in and close a finished field.
module vphp_bit_step (
  input  vphp_pkg::parse_state_t cur,
  input  logic                   bit_in,
  output vphp_pkg::parse_state_t nxt,
  output logic                   fire,
  output vphp_pkg::status_t      status
);
  import vphp_pkg::*;

  logic [AccW-1:0] acc_n;
  logic [4:0]      left_n;
  logic            active;
  logic            field_done;
  logic            err;
  logic            ok_end;
  status_t         code;
  phase_t          next_ph;
  logic            emit;
  phase_t          ph_nxt;
  logic [4:0]      left_nxt;
  logic [AccW-1:0] acc_nxt;
  hdr_fields_t     saved_nxt;

  assign acc_n      = {cur.acc[AccW-2:0], bit_in};
  assign left_n     = (cur.left != 5'd0) ? cur.left - 5'd1 : 5'd0;
  assign active     = !(cur.phase inside {PH_IDLE, PH_DONE});
  assign field_done = active && (left_n == 5'd0);
  assign emit       = field_done && (err || ok_end);

  always_comb begin
    next_ph = phase_t'(cur.phase + 5'd1);
    err     = 1'b0;
    ok_end  = 1'b0;
    code    = ST_OK;
    case (cur.phase)
      PH_START: begin
        if (acc_n != START_CODE) begin
          err  = 1'b1;
          code = ST_BAD_START;
        end
      end
      PH_MARKER: begin
        if (acc_n != 22'd1) begin
          err  = 1'b1;
          code = ST_BAD_MARKER;
        end
      end
      PH_ID: begin
        if (acc_n != 22'd0) begin
          err  = 1'b1;
          code = ST_BAD_ID;
        end
      end
      PH_FORMAT: begin
        next_ph = (acc_n[2:0] == 3'd7) ? PH_X_UFEP : PH_B_PTYPE;
      end
      PH_B_CPM:  next_ph = PH_PEI;
      PH_X_UFEP: begin
        if (acc_n != 22'd1) begin
          err  = 1'b1;
          code = ST_BAD_EXT;
        end
      end
      PH_X_SRC: begin
        if (acc_n != 22'd6) begin
          err  = 1'b1;
          code = ST_BAD_SRC;
        end
      end
      PH_PEI: begin
        if (acc_n == 22'd0) begin
          ok_end = 1'b1;
        end else begin
          next_ph = PH_PSUPP;
        end
      end
      PH_PSUPP:  next_ph = PH_PEI;
      default:   ;
    endcase
  end

  always_comb begin
    ph_nxt   = cur.phase;
    left_nxt = cur.left;
    acc_nxt  = cur.acc;
    if (active) begin
      if (!field_done) begin
        left_nxt = left_n;
        acc_nxt  = acc_n;
      end else if (emit) begin
        ph_nxt   = PH_DONE;
        left_nxt = 5'd0;
        acc_nxt  = '0;
      end else begin
        ph_nxt   = next_ph;
        left_nxt = phase_len(next_ph);
        acc_nxt  = '0;
      end
    end
  end

  always_comb begin
    saved_nxt = cur.saved;
    fire      = emit;
    status    = emit ? code : ST_OK;
    if (field_done && !err) begin
      case (cur.phase)
        PH_FORMAT: begin
          saved_nxt.fmt = acc_n[2:0];
          if (acc_n[2:0] == 3'd7) begin
            saved_nxt.ext = 1'b1;
          end else begin
            saved_nxt.width  = fmt_width(acc_n[2:0]);
            saved_nxt.height = fmt_height(acc_n[2:0]);
          end
        end
        PH_B_PTYPE:  saved_nxt.ptype  = {3'b000, acc_n[0]};
        PH_B_UMV:    saved_nxt.umv    = acc_n[0];
        PH_B_SAC:    saved_nxt.sac    = acc_n[0];
        PH_B_AP:     saved_nxt.ap     = acc_n[0];
        PH_B_PB:     saved_nxt.pb     = acc_n[0];
        PH_B_QS:     saved_nxt.qs     = acc_n[4:0];
        PH_X_PTYPE:  saved_nxt.ptype  = {1'b0, acc_n[2:0]} + 4'd1;
        PH_X_WIDTH:  saved_nxt.width  = {{1'b0, acc_n[8:0]} + 10'd1, 2'b00};
        PH_X_HEIGHT: saved_nxt.height = {acc_n[8:0], 2'b00};
        PH_X_QS:     saved_nxt.qs     = acc_n[4:0];
        default:     ;
      endcase
    end
  end

  assign nxt = '{phase: ph_nxt, left: left_nxt, acc: acc_nxt, saved: saved_nxt};

endmodule

// ----- sv/vphp_byte_engine.sv -----
// Parser state register and the eight chained bit steps for one byte.
`include "video_picture_header_parser_core_macros.svh"
module vphp_byte_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [7:0]            byte_in,
  input  logic                  start_in,
  output logic                  res_valid,
  output vphp_pkg::hdr_result_t res
);
  import vphp_pkg::*;

  parse_state_t state_r;
  parse_state_t state_nxt;
  parse_state_t chain [0:8];
  logic [7:0]   fire_vec;
  status_t      st_vec [0:7];
  status_t      st_any;

  always_comb begin
    if (start_in) begin
      chain[0] = '{phase: PH_START, left: phase_len(PH_START), acc: '0, saved: '0};
    end else begin
      chain[0] = state_r;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_step
    vphp_bit_step u_step (
      .cur    (chain[i]),
      .bit_in (byte_in[7-i]),
      .nxt    (chain[i+1]),
      .fire   (fire_vec[i]),
      .status (st_vec[i])
    );
  end

  always_comb begin
    st_any = ST_OK;
    for (int k = 0; k < 8; k++) begin
      st_any = status_t'(st_any | st_vec[k]);
    end
  end

  assign res_valid  = en && (fire_vec != 8'd0);
  assign res.status = st_any;
  assign res.fields = (st_any == ST_OK) ? chain[8].saved : '0;

  assign state_nxt = en ? chain[8] : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, left: 5'd0, acc: '0, saved: '0};
    end else begin
      state_r <= state_nxt;
    end
  end

  `VPHP_ASSERT(a_one_fire, $onehot0(fire_vec))
  `VPHP_ASSERT_NXT(a_done_after_res, res_valid, state_r.phase == PH_DONE)
  `VPHP_ASSERT_NXT(a_start_leaves_idle, en && start_in, state_r.phase != PH_IDLE)

endmodule

// ----- sv/video_picture_header_parser_core.sv -----
// Top level of the picture header parser: input beat register, engine, result register.
// Usage:
//   Slave channel in_*: one header byte per beat in in_tdata[7:0], sent most
//   significant bit first; in_tuser marks the first byte of a header and
//   restarts the parser on that byte.
//   Master channel out_*: at most one result beat per header, issued at the end
//   of the header or at the first error; on error every field but status is 0.
//   Bytes before the first start flag, or after a result, are dropped until
//   the next start flag.
//   Each accepted byte is held in the input register and parsed from there;
//   its result beat, if any, is registered in the result register that drives out_tvalid.
//   Throughput: one byte per cycle unless stalled; all eight bit steps of a
//   byte resolve combinationally in the engine, which holds the only parser state.
//   Reset: synchronous rst_n low empties both beat registers and returns the
//   parser to idle, waiting for a start flag.
//   Stall: while out_tvalid is high and out_tready low the result is held and
//   the byte engine stops; one byte more is held in the input register, then
//   in_tready drops.
`include "video_picture_header_parser_core_macros.svh"
module video_picture_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] header_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [3] extended_mode, [6:4] source_format, [18:7] frame_width,
  // [29:19] frame_height, [33:30] picture_type, [34] free_mv,
  // [35] arith_coding, [36] advanced_pred, [37] pb_frame, [42:38] quant_scale
  output logic [47:0] out_tdata
);
  import vphp_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_start_r;
  logic        proc;
  logic        eng_valid;
  hdr_result_t eng_res;
  logic        out_valid_r;
  hdr_result_t out_res_r;

  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  vphp_byte_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (proc),
    .byte_in   (s1_data_r),
    .start_in  (s1_start_r),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.fields.qs, out_res_r.fields.pb, out_res_r.fields.ap,
                       out_res_r.fields.sac, out_res_r.fields.umv, out_res_r.fields.ptype,
                       out_res_r.fields.height, out_res_r.fields.width,
                       out_res_r.fields.fmt, out_res_r.fields.ext, out_res_r.status};

  `VPHP_ASSERT_IMP(a_err_fields_zero, out_valid_r && (out_res_r.status != ST_OK),
                   out_res_r.fields == '0)
  `VPHP_ASSERT_IMP(a_status_range, out_valid_r, out_res_r.status <= ST_BAD_SRC)
  `VPHP_ASSERT_NXT(a_s1_hold, s1_valid_r && !proc, s1_valid_r && $stable(s1_data_r))

endmodule
